// ----- rtl/vfm_pkg.sv -----
// Package for the voxel face mesher: sizes, queue entry and status types,
// material lookup and the per-face corner and UV offset tables.
// Depends on nothing; every module and the bench import it, the two interfaces do not.
package vfm_pkg;

   localparam int unsigned CHUNK_WIDTH  = 16;
   localparam int unsigned CHUNK_HEIGHT = 256;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int unsigned IDX_W = 21;

   localparam logic [8:0] UV_STEP = 9'd15;

   // Block kind codes
   localparam logic [3:0] KIND_EMPTY   = 4'd0;
   localparam logic [3:0] KIND_DIRT    = 4'd1;
   localparam logic [3:0] KIND_GRASS   = 4'd2;
   localparam logic [3:0] KIND_STONE   = 4'd3;
   localparam logic [3:0] KIND_WOOD    = 4'd4;
   localparam logic [3:0] KIND_LEAF    = 4'd5;
   localparam logic [3:0] KIND_BEDROCK = 4'd6;
   localparam logic [3:0] KIND_LAVA    = 4'd7;
   localparam logic [3:0] KIND_WATER   = 4'd8;
   localparam logic [3:0] KIND_ICE     = 4'd9;
   localparam logic [3:0] KIND_COAL    = 4'd10;

   // Face codes
   localparam logic [2:0] FACE_NEG_X = 3'd0;
   localparam logic [2:0] FACE_POS_X = 3'd1;
   localparam logic [2:0] FACE_NEG_Y = 3'd2;
   localparam logic [2:0] FACE_POS_Y = 3'd3;
   localparam logic [2:0] FACE_NEG_Z = 3'd4;
   localparam logic [2:0] FACE_POS_Z = 3'd5;

   localparam logic [2:0] LAST_CORNER = 3'd3;

   typedef struct packed {
      logic [3:0]       voxel_x;
      logic [7:0]       voxel_y;
      logic [3:0]       voxel_z;
      logic [3:0]       block_kind;
      logic [5:0]       open_faces;
      logic [IDX_W-1:0] base_index;
   } vfm_job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } vfm_qstat_type;

   typedef struct packed {
      logic [8:0] tile_u;
      logic [8:0] tile_v;
      logic       animated;
      logic [8:0] power_value;
   } vfm_mat_type;

   // Corner offsets {x,y,z} per face, per vertex
   localparam logic [2:0] CORNER_TAB [0:5][0:3] = '{
      '{3'b000, 3'b001, 3'b011, 3'b010},
      '{3'b100, 3'b110, 3'b111, 3'b101},
      '{3'b000, 3'b100, 3'b101, 3'b001},
      '{3'b010, 3'b011, 3'b111, 3'b110},
      '{3'b000, 3'b010, 3'b110, 3'b100},
      '{3'b101, 3'b111, 3'b011, 3'b001}
   };

   // UV offset flags {u,v} per face, per vertex; a set flag adds UV_STEP
   localparam logic [1:0] UVOFF_TAB [0:5][0:3] = '{
      '{2'b00, 2'b10, 2'b11, 2'b01},
      '{2'b10, 2'b11, 2'b01, 2'b00},
      '{2'b10, 2'b11, 2'b01, 2'b00},
      '{2'b11, 2'b01, 2'b00, 2'b10},
      '{2'b10, 2'b11, 2'b01, 2'b00},
      '{2'b10, 2'b11, 2'b01, 2'b00}
   };

   // Tile origin, animation and power per kind; grass swaps tile on top and bottom
   function automatic vfm_mat_type mat_lookup(input logic [3:0] kind, input logic [2:0] face);
      vfm_mat_type m;
      case (kind)
         KIND_DIRT:    m = '{9'd32,  9'd240, 1'b0, 9'd500};
         KIND_GRASS:   m = '{9'd48,  9'd240, 1'b0, 9'd500};
         KIND_STONE:   m = '{9'd0,   9'd240, 1'b0, 9'd200};
         KIND_WOOD:    m = '{9'd112, 9'd160, 1'b0, 9'd300};
         KIND_LEAF:    m = '{9'd64,  9'd192, 1'b0, 9'd50};
         KIND_BEDROCK: m = '{9'd16,  9'd224, 1'b0, 9'd400};
         KIND_LAVA:    m = '{9'd240, 9'd16,  1'b1, 9'd10};
         KIND_WATER:   m = '{9'd224, 9'd48,  1'b1, 9'd10};
         KIND_ICE:     m = '{9'd128, 9'd224, 1'b0, 9'd2};
         KIND_COAL:    m = '{9'd80,  9'd208, 1'b0, 9'd200};
         default:      m = '{9'd256, 9'd256, 1'b1, 9'd1};
      endcase
      if (kind == KIND_GRASS && face == FACE_POS_Y) begin
         m.tile_u = 9'd128;
         m.tile_v = 9'd208;
      end
      if (kind == KIND_GRASS && face == FACE_NEG_Y) begin
         m.tile_u = 9'd32;
         m.tile_v = 9'd240;
      end
      return m;
   endfunction

endpackage

// ----- rtl/vfm_req_if.sv -----
// Voxel request channel: valid/ready plus one voxel per beat.
// Depends on nothing.
interface vfm_req_if;
   logic       valid;
   logic       ready;
   logic       chunk_start;
   logic [3:0] voxel_x;
   logic [7:0] voxel_y;
   logic [3:0] voxel_z;
   logic [3:0] block_kind;
   logic [5:0] open_faces;

   modport source (output valid, chunk_start, voxel_x, voxel_y, voxel_z, block_kind,
                   open_faces, input ready);
   modport sink   (input valid, chunk_start, voxel_x, voxel_y, voxel_z, block_kind,
                   open_faces, output ready);
endinterface

// ----- rtl/vfm_rsp_if.sv -----
// Vertex response channel: valid/ready plus one vertex per beat.
// Depends on nothing.
interface vfm_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  corner_x;
   logic [8:0]  corner_y;
   logic [4:0]  corner_z;
   logic [2:0]  face_code;
   logic [8:0]  tex_u;
   logic [8:0]  tex_v;
   logic        animated;
   logic [8:0]  power_value;
   logic [20:0] vertex_index;
   logic        last_vertex;

   modport source (output valid, corner_x, corner_y, corner_z, face_code, tex_u, tex_v,
                   animated, power_value, vertex_index, last_vertex, input ready);
   modport sink   (input valid, corner_x, corner_y, corner_z, face_code, tex_u, tex_v,
                   animated, power_value, vertex_index, last_vertex, output ready);
endinterface

// ----- rtl/vfm_front.sv -----
// Front end: accepts voxels, keeps the running vertex counter and queues visible voxels.
// Depends on vfm_pkg and vfm_req_if.
module vfm_front (
   input  logic                  clock,
   input  logic                  reset,
   vfm_req_if.sink               req_ch,
   input  vfm_pkg::vfm_qstat_type q_stat,
   output logic                  q_push,
   output vfm_pkg::vfm_job_type  q_job
);
   import vfm_pkg::*;

   logic [IDX_W-1:0] count_ff;
   logic [IDX_W-1:0] count_in;
   logic [IDX_W-1:0] base;
   logic [2:0]       n_faces;
   logic             accept;
   logic             solid;

   assign req_ch.ready = !reset && !q_stat.full;
   assign accept       = req_ch.valid && req_ch.ready;
   assign solid        = req_ch.block_kind != KIND_EMPTY;

   always_comb begin
      n_faces = 3'd0;
      for (int i = 0; i < 6; i++) begin
         n_faces = n_faces + {2'd0, req_ch.open_faces[i]};
      end
   end

   assign base = req_ch.chunk_start ? '0 : count_ff;

   // Reserve four indices per open face; empty voxels only apply the chunk clear
   assign count_in = solid ? base + IDX_W'({n_faces, 2'b00}) : base;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (accept) begin
         count_ff <= count_in;
      end
   end

   assign q_push = accept && solid && (req_ch.open_faces != 6'd0);

   // Chunk sizes are powers of two, so the wrap is a plain bit select
   always_comb begin
      q_job.voxel_x    = 4'(req_ch.voxel_x % CHUNK_WIDTH);
      q_job.voxel_y    = 8'(req_ch.voxel_y % CHUNK_HEIGHT);
      q_job.voxel_z    = 4'(req_ch.voxel_z % CHUNK_WIDTH);
      q_job.block_kind = req_ch.block_kind;
      q_job.open_faces = req_ch.open_faces;
      q_job.base_index = base;
   end

endmodule

// ----- rtl/vfm_queue.sv -----
// Short job queue between front and back end.
// Depends on vfm_pkg.
module vfm_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  vfm_pkg::vfm_job_type   push_job,
   input  logic                   pop,
   output vfm_pkg::vfm_job_type   head_job,
   output vfm_pkg::vfm_qstat_type stat
);
   import vfm_pkg::*;

   vfm_job_type        entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff;
   logic [QPTR_W-1:0]  rd_ptr_ff;
   logic [QCNT_W-1:0]  count_ff;

   function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
      return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign stat.full  = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign stat.empty = count_ff == '0;
   assign head_job   = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ----- rtl/vfm_back.sv -----
// Back end: walks the open faces of the head voxel, one vertex per beat into an output register.
// Depends on vfm_pkg and vfm_rsp_if.
module vfm_back (
   input  logic                   clock,
   input  logic                   reset,
   input  vfm_pkg::vfm_job_type   head_job,
   input  vfm_pkg::vfm_qstat_type q_stat,
   output logic                   q_pop,
   vfm_rsp_if.source              rsp_ch
);
   import vfm_pkg::*;

   logic             started_ff;
   logic [5:0]       rem_ff;
   logic [1:0]       corner_ff;
   logic [IDX_W-1:0] idx_ff;

   logic             valid_ff;
   logic [4:0]       cx_ff;
   logic [8:0]       cy_ff;
   logic [4:0]       cz_ff;
   logic [2:0]       face_ff;
   logic [8:0]       u_ff;
   logic [8:0]       v_ff;
   logic             anim_ff;
   logic [8:0]       power_ff;
   logic [IDX_W-1:0] vidx_ff;
   logic             last_ff;

   logic [5:0]       rem_cur;
   logic [5:0]       rem_next;
   logic [IDX_W-1:0] idx_cur;
   logic [2:0]       face;
   logic             last;
   logic             advance;
   logic             fire;
   vfm_mat_type      mat;
   logic [2:0]       coff;
   logic [1:0]       uvoff;

   assign rem_cur = started_ff ? rem_ff : head_job.open_faces;
   assign idx_cur = started_ff ? idx_ff : head_job.base_index;

   // Lowest open face still to do
   always_comb begin
      face = FACE_NEG_X;
      for (int i = 5; i >= 0; i--) begin
         if (rem_cur[i]) begin
            face = 3'(i);
         end
      end
   end

   assign rem_next = ({1'b0, corner_ff} == LAST_CORNER) ? (rem_cur & ~(6'd1 << face)) : rem_cur;
   assign last     = rem_next == 6'd0;
   assign advance  = !valid_ff || rsp_ch.ready;
   assign fire     = advance && !q_stat.empty;
   assign q_pop    = fire && last;

   assign mat   = mat_lookup(head_job.block_kind, face);
   assign coff  = CORNER_TAB[face][corner_ff];
   assign uvoff = UVOFF_TAB[face][corner_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         corner_ff  <= 2'd0;
         valid_ff   <= 1'b0;
      end else begin
         if (advance) begin
            valid_ff <= fire;
         end
         if (fire) begin
            corner_ff  <= corner_ff + 1'b1;
            started_ff <= !last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rem_ff   <= rem_next;
         idx_ff   <= idx_cur + 1'b1;
         cx_ff    <= {1'b0, head_job.voxel_x} + {4'd0, coff[2]};
         cy_ff    <= {1'b0, head_job.voxel_y} + {8'd0, coff[1]};
         cz_ff    <= {1'b0, head_job.voxel_z} + {4'd0, coff[0]};
         face_ff  <= face;
         u_ff     <= mat.tile_u + (uvoff[1] ? UV_STEP : 9'd0);
         v_ff     <= mat.tile_v + (uvoff[0] ? UV_STEP : 9'd0);
         anim_ff  <= mat.animated;
         power_ff <= mat.power_value;
         vidx_ff  <= idx_cur;
         last_ff  <= last;
      end
   end

   assign rsp_ch.valid        = valid_ff;
   assign rsp_ch.corner_x     = cx_ff;
   assign rsp_ch.corner_y     = cy_ff;
   assign rsp_ch.corner_z     = cz_ff;
   assign rsp_ch.face_code    = face_ff;
   assign rsp_ch.tex_u        = u_ff;
   assign rsp_ch.tex_v        = v_ff;
   assign rsp_ch.animated     = anim_ff;
   assign rsp_ch.power_value  = power_ff;
   assign rsp_ch.vertex_index = vidx_ff;
   assign rsp_ch.last_vertex  = last_ff;

endmodule

// ----- rtl/voxel_face_mesher.sv -----
// Voxel face mesher: top level joining front end, job queue and back end.
// A solid voxel with open faces is queued; at the queue head, the back end registers its
// vertices. Throughput: one vertex per cycle unless rsp_ch stalls, four per open face;
// voxels with no open face, or empty ones, use only their request beat in the front end.
// Reset (synchronous): clears the vertex counter, empties the queue, drops any pending vertex.
// Depends on vfm_pkg, vfm_req_if, vfm_rsp_if, vfm_front, vfm_queue and vfm_back.
module voxel_face_mesher (
   input  logic      clock,
   input  logic      reset,
   vfm_req_if.sink   req_ch,
   vfm_rsp_if.source rsp_ch
);
   import vfm_pkg::*;

   // Front-to-back hand-off through the job queue
   vfm_job_type   push_job;
   vfm_job_type   head_job;
   vfm_qstat_type q_stat;
   logic          q_push;
   logic          q_pop;

   // Front end: classify each voxel, reserve its index range, queue it if it has faces.
   // The counter advances at the request beat, so later voxels never wait on the back end
   // to learn their base index.
   vfm_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .q_stat  (q_stat),
      .q_push  (q_push),
      .q_job   (push_job)
   );

   // Queue: lets the front end keep taking voxels while the back end streams vertices
   vfm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .head_job (head_job),
      .stat     (q_stat)
   );

   // Back end: one vertex per beat; release the queue head on its last vertex
   vfm_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_job (head_job),
      .q_stat   (q_stat),
      .q_pop    (q_pop),
      .rsp_ch   (rsp_ch)
   );

   // Never push into a full queue
   assert property (@(posedge clock) disable iff (reset) q_push |-> !q_stat.full)
      else $error("push into full queue");

   // Never pop an empty queue
   assert property (@(posedge clock) disable iff (reset) q_pop |-> !q_stat.empty)
      else $error("pop from empty queue");

   // Only queued voxels with an open face reach the back end
   assert property (@(posedge clock) disable iff (reset)
                    !q_stat.empty |-> head_job.open_faces != 6'd0 &&
                                      head_job.block_kind != KIND_EMPTY)
      else $error("queued voxel has nothing to emit");

   // A vertex carries a real face code
   assert property (@(posedge clock) disable iff (reset)
                    rsp_ch.valid |-> rsp_ch.face_code <= FACE_POS_Z)
      else $error("face code out of range");

endmodule

// ----- tb/sv/voxel_face_mesher_tb.sv -----
// Self-checking bench for voxel_face_mesher: directed and random voxels in, vertices checked
// against a scoreboard that rebuilds every quad from the voxel fields.
// Depends on vfm_pkg, vfm_req_if, vfm_rsp_if and the voxel_face_mesher RTL.
module voxel_face_mesher_tb;
   import vfm_pkg::*;

   localparam int RANDOM_VOXELS = 410;
   localparam int CALM_VOXELS   = 80;
   localparam int HOLD_AT_VOXEL = 150;
   localparam int LONG_HOLD     = 300;
   localparam int IDLE_LIMIT    = 2000;
   localparam int TAIL_CYCLES   = 20;
   localparam int REPORT_LIMIT  = 10;

   // Corner offsets {dx,dy,dz} of the four vertices of each face, faces in -x..+z order
   localparam logic [2:0] QUAD_CORNERS [0:5][0:3] = '{
      '{3'b000, 3'b001, 3'b011, 3'b010},
      '{3'b100, 3'b110, 3'b111, 3'b101},
      '{3'b000, 3'b100, 3'b101, 3'b001},
      '{3'b010, 3'b011, 3'b111, 3'b110},
      '{3'b000, 3'b010, 3'b110, 3'b100},
      '{3'b101, 3'b111, 3'b011, 3'b001}
   };

   // Tile step flags {u,v} per vertex: a set flag moves to the far edge of the tile
   localparam logic [1:0] QUAD_UV_STEPS [0:5][0:3] = '{
      '{2'b00, 2'b10, 2'b11, 2'b01},
      '{2'b10, 2'b11, 2'b01, 2'b00},
      '{2'b10, 2'b11, 2'b01, 2'b00},
      '{2'b11, 2'b01, 2'b00, 2'b10},
      '{2'b10, 2'b11, 2'b01, 2'b00},
      '{2'b10, 2'b11, 2'b01, 2'b00}
   };

   typedef struct packed {
      logic       chunk_start;
      logic [3:0] voxel_x;
      logic [7:0] voxel_y;
      logic [3:0] voxel_z;
      logic [3:0] block_kind;
      logic [5:0] open_faces;
   } voxel_rec_type;

   typedef struct packed {
      logic [4:0]       corner_x;
      logic [8:0]       corner_y;
      logic [4:0]       corner_z;
      logic [2:0]       face_code;
      logic [8:0]       tex_u;
      logic [8:0]       tex_v;
      logic             animated;
      logic [8:0]       power_value;
      logic [IDX_W-1:0] vertex_index;
      logic             last_vertex;
   } vertex_rec_type;

   // Holds the running vertex number and the vertices still owed by the block
   class vertex_scoreboard;
      logic [IDX_W-1:0] next_index;
      vertex_rec_type   owed_vertices[$];
      int               mismatch_count;
      bit               failed;

      function new();
         next_index     = '0;
         mismatch_count = 0;
         failed         = 1'b0;
      endfunction

      function int pending();
         return owed_vertices.size();
      endfunction

      // Material of a kind on a given face; grass swaps its tile on top and bottom
      function void tile_of(input logic [3:0] kind, input logic [2:0] face,
                            output logic [8:0] u, output logic [8:0] v,
                            output logic anim, output logic [8:0] power);
         case (kind)
            KIND_DIRT:    begin u = 9'd32;  v = 9'd240; anim = 1'b0; power = 9'd500; end
            KIND_GRASS:   begin u = 9'd48;  v = 9'd240; anim = 1'b0; power = 9'd500; end
            KIND_STONE:   begin u = 9'd0;   v = 9'd240; anim = 1'b0; power = 9'd200; end
            KIND_WOOD:    begin u = 9'd112; v = 9'd160; anim = 1'b0; power = 9'd300; end
            KIND_LEAF:    begin u = 9'd64;  v = 9'd192; anim = 1'b0; power = 9'd50;  end
            KIND_BEDROCK: begin u = 9'd16;  v = 9'd224; anim = 1'b0; power = 9'd400; end
            KIND_LAVA:    begin u = 9'd240; v = 9'd16;  anim = 1'b1; power = 9'd10;  end
            KIND_WATER:   begin u = 9'd224; v = 9'd48;  anim = 1'b1; power = 9'd10;  end
            KIND_ICE:     begin u = 9'd128; v = 9'd224; anim = 1'b0; power = 9'd2;   end
            KIND_COAL:    begin u = 9'd80;  v = 9'd208; anim = 1'b0; power = 9'd200; end
            default:      begin u = 9'd256; v = 9'd256; anim = 1'b1; power = 9'd1;   end
         endcase
         if (kind == KIND_GRASS && face == FACE_POS_Y) begin
            u = 9'd128;
            v = 9'd208;
         end
         if (kind == KIND_GRASS && face == FACE_NEG_Y) begin
            u = 9'd32;
            v = 9'd240;
         end
      endfunction

      // Queue the quads of one accepted voxel
      function void note_voxel(voxel_rec_type vox);
         vertex_rec_type vt;
         logic [8:0]     tile_u;
         logic [8:0]     tile_v;
         logic [8:0]     power;
         logic           anim;
         logic [2:0]     ofs;
         logic [1:0]     steps;
         if (vox.chunk_start) begin
            next_index = '0;
         end
         if (vox.block_kind == KIND_EMPTY) begin
            return;
         end
         for (int f = 0; f < 6; f++) begin
            if (vox.open_faces[f]) begin
               tile_of(vox.block_kind, 3'(f), tile_u, tile_v, anim, power);
               for (int c = 0; c < 4; c++) begin
                  ofs             = QUAD_CORNERS[f][c];
                  steps           = QUAD_UV_STEPS[f][c];
                  vt.corner_x     = {1'b0, vox.voxel_x} + {4'd0, ofs[2]};
                  vt.corner_y     = {1'b0, vox.voxel_y} + {8'd0, ofs[1]};
                  vt.corner_z     = {1'b0, vox.voxel_z} + {4'd0, ofs[0]};
                  vt.face_code    = 3'(f);
                  vt.tex_u        = tile_u + (steps[1] ? UV_STEP : 9'd0);
                  vt.tex_v        = tile_v + (steps[0] ? UV_STEP : 9'd0);
                  vt.animated     = anim;
                  vt.power_value  = power;
                  vt.vertex_index = next_index;
                  // last corner of the highest open face closes the voxel
                  vt.last_vertex  = (c == 3) && ((vox.open_faces >> (f + 1)) == 6'd0);
                  owed_vertices   = {owed_vertices, vt};
                  next_index = next_index + 1'b1;
               end
            end
         end
      endfunction

      function string describe(vertex_rec_type t);
         return $sformatf({"pos=(%0d,%0d,%0d) face=%0d uv=(%0d,%0d) ",
                           "anim=%0d power=%0d index=%0d last=%0d"},
                          t.corner_x, t.corner_y, t.corner_z, t.face_code, t.tex_u, t.tex_v,
                          t.animated, t.power_value, t.vertex_index, t.last_vertex);
      endfunction

      function void check_vertex(vertex_rec_type got);
         vertex_rec_type want;
         if (owed_vertices.size() == 0) begin
            failed = 1'b1;
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("unexpected vertex: %s", describe(got));
            end
            return;
         end
         want = owed_vertices.pop_front();
         if (got !== want) begin
            failed = 1'b1;
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("vertex mismatch at %0t", $time);
               $display("   expected %s", describe(want));
               $display("   actual   %s", describe(got));
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   vfm_req_if req_bus();
   vfm_rsp_if rsp_bus();

   vertex_scoreboard sb;
   bit calm;           // set by the sender for the idle-free last stretch
   int hold_asks;      // bumped by the sender to ask the receiver for a long hold

   voxel_face_mesher i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Offer one voxel, maybe after a short idle burst, and hold it until its beat is taken
   task automatic send_voxel(input logic cs, input logic [3:0] x, input logic [7:0] y,
                             input logic [3:0] z, input logic [3:0] kind,
                             input logic [5:0] faces);
      voxel_rec_type vox;
      int            gap;
      vox = '{cs, x, y, z, kind, faces};
      if (!calm && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 5);
         repeat (gap) begin
            @(negedge clock);
            req_bus.valid <= 1'b0;
         end
      end
      @(negedge clock);
      req_bus.valid       <= 1'b1;
      req_bus.chunk_start <= vox.chunk_start;
      req_bus.voxel_x     <= vox.voxel_x;
      req_bus.voxel_y     <= vox.voxel_y;
      req_bus.voxel_z     <= vox.voxel_z;
      req_bus.block_kind  <= vox.block_kind;
      req_bus.open_faces  <= vox.open_faces;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      sb.note_voxel(vox);
   endtask

   // Drop valid and hold until every owed vertex has come back
   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      int         roll;
      logic [3:0] kind;
      logic [5:0] faces;
      logic [7:0] height;
      sb        = new();
      calm      = 1'b0;
      hold_asks = 0;
      req_bus.valid       <= 1'b0;
      req_bus.chunk_start <= 1'b0;
      req_bus.voxel_x     <= '0;
      req_bus.voxel_y     <= '0;
      req_bus.voxel_z     <= '0;
      req_bus.block_kind  <= KIND_EMPTY;
      req_bus.open_faces  <= '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: corners of the chunk, every material, grass faces, empty and closed voxels
      send_voxel(1'b1, 4'd0, 8'd0, 4'd0, KIND_DIRT, 6'h3F);
      send_voxel(1'b0, 4'd15, 8'd255, 4'd15, KIND_STONE, 6'h3F);
      send_voxel(1'b0, 4'd7, 8'd64, 4'd9, KIND_GRASS, 6'h3F);
      send_voxel(1'b0, 4'd1, 8'd1, 4'd1, KIND_WOOD, 6'b000001);
      send_voxel(1'b0, 4'd2, 8'd3, 4'd4, KIND_LEAF, 6'b000010);
      send_voxel(1'b0, 4'd5, 8'd6, 4'd7, KIND_BEDROCK, 6'b000100);
      send_voxel(1'b0, 4'd8, 8'd9, 4'd10, KIND_LAVA, 6'b001000);
      send_voxel(1'b0, 4'd11, 8'd12, 4'd13, KIND_WATER, 6'b010000);
      send_voxel(1'b0, 4'd14, 8'd200, 4'd0, KIND_ICE, 6'b100000);
      send_voxel(1'b0, 4'd3, 8'd128, 4'd12, KIND_COAL, 6'b101010);
      // kinds above coal fall back to the default material
      for (int k = KIND_COAL + 1; k <= 15; k++) begin
         send_voxel(1'b0, 4'(k), 8'(k * 16), 4'(15 - k), 4'(k), 6'b010101);
      end
      send_voxel(1'b0, 4'd6, 8'd6, 4'd6, KIND_EMPTY, 6'h3F);
      send_voxel(1'b0, 4'd9, 8'd99, 4'd9, KIND_STONE, 6'd0);
      send_voxel(1'b1, 4'd4, 8'd40, 4'd4, KIND_EMPTY, 6'h3F);
      send_voxel(1'b0, 4'd8, 8'd128, 4'd8, KIND_DIRT, 6'b001100);
      send_voxel(1'b0, 4'd0, 8'd255, 4'd15, KIND_GRASS, 6'b001100);
      wait_drained();

      // Random: chunks of mostly surface voxels, with empty and fully buried ones mixed in
      for (int n = 0; n < RANDOM_VOXELS; n++) begin
         if (n == RANDOM_VOXELS - CALM_VOXELS) begin
            wait_drained();
            calm = 1'b1;
         end
         if (n == HOLD_AT_VOXEL) begin
            hold_asks++;
         end
         roll = $urandom_range(0, 99);
         kind = (roll < 10) ? KIND_EMPTY : 4'($urandom_range(1, 15));
         roll = $urandom_range(0, 99);
         if (roll < 15) begin
            faces = 6'd0;
         end else if (roll < 45) begin
            faces = 6'd1 << $urandom_range(0, 5);
         end else begin
            faces = 6'($urandom_range(0, 63));
         end
         roll = $urandom_range(0, 9);
         height = (roll == 0) ? 8'd0 : (roll == 1) ? 8'd255 : 8'($urandom_range(0, 255));
         send_voxel(1'($urandom_range(0, 15) == 0), 4'($urandom_range(0, 15)), height,
                    4'($urandom_range(0, 15)), kind, faces);
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (!sb.failed && sb.pending() == 0) begin
         $display("voxel_face_mesher test passed");
      end else begin
         $display("voxel_face_mesher test failed");
      end
      $finish;
   end

   // Receiver: random short stalls, one long hold on request, none in the calm stretch
   initial begin : rsp_ready_drive
      int gap;
      int hold_served;
      hold_served = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (hold_asks != hold_served) begin
            // hold off long enough for the queue to fill and back-pressure the voxels
            hold_served = hold_asks;
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD - 1) @(negedge clock);
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 5);
            rsp_bus.ready <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Capture every vertex beat and hand it to the scoreboard
   always @(posedge clock) begin : rsp_monitor
      vertex_rec_type got;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         got.corner_x     = rsp_bus.corner_x;
         got.corner_y     = rsp_bus.corner_y;
         got.corner_z     = rsp_bus.corner_z;
         got.face_code    = rsp_bus.face_code;
         got.tex_u        = rsp_bus.tex_u;
         got.tex_v        = rsp_bus.tex_v;
         got.animated     = rsp_bus.animated;
         got.power_value  = rsp_bus.power_value;
         got.vertex_index = rsp_bus.vertex_index;
         got.last_vertex  = rsp_bus.last_vertex;
         sb.check_vertex(got);
      end
   end

   // Watchdog: give up once no beat has moved on either channel for too long
   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_bus.valid === 1'b1 && req_bus.ready === 1'b1)
                   || (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
            idle = 0;
         end else begin
            idle++;
         end
      end
      $display("voxel_face_mesher test failed");
      $finish;
   end

endmodule
